/* design/lkv_pkg.sv */
package lkv_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 31;
  localparam int CAP_W       = 5;
  localparam int CAP_RESET   = 16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [VAL_W-1:0] value;
  } res_t;

endpackage

/* design/lkv_ram.sv */
module lkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/lkv_engine.sv */
module lkv_engine #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int RW = IW,
  localparam int WW = lkv_pkg::KEY_W + lkv_pkg::VAL_W + RW
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  logic [lkv_pkg::KEY_W-1:0] in_key,
  input  logic [lkv_pkg::VAL_W-1:0] in_value,
  input  logic                      cfg_valid,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_data,
  output lkv_pkg::res_t             res,
  input  logic                      res_ready,
  output logic                      ram_we,
  output logic [IW-1:0]             ram_waddr,
  output logic [WW-1:0]             ram_wdata,
  output logic [IW-1:0]             ram_raddr,
  input  logic [WW-1:0]             ram_rdata
);

  localparam int KW = lkv_pkg::KEY_W;
  localparam int VW = lkv_pkg::VAL_W;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_RESULT = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;

  logic [2:0]               state_r, state_nxt;
  logic [ENTRIES-1:0]       valid_r, valid_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [lkv_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic                     pend_r, pend_nxt;
  logic [IW-1:0]            pidx_r, pidx_nxt;
  logic                     found_r, found_nxt;
  logic                     vfound_r, vfound_nxt;
  logic                     ffound_r, ffound_nxt;
  logic                     ins_r, ins_nxt;

  logic                     op_r, op_nxt;
  logic [KW-1:0]            key_r, key_nxt;
  logic [VW-1:0]            val_r, val_nxt;
  logic [IW-1:0]            fidx_r, fidx_nxt;
  logic [RW-1:0]            frank_r, frank_nxt;
  logic [VW-1:0]            fval_r, fval_nxt;
  logic [IW-1:0]            vidx_r, vidx_nxt;
  logic [RW-1:0]            vrank_r, vrank_nxt;
  logic [IW-1:0]            fridx_r, fridx_nxt;
  logic [IW-1:0]            tidx_r, tidx_nxt;
  logic [VW-1:0]            tval_r, tval_nxt;
  logic [RW-1:0]            thr_r, thr_nxt;

  logic [KW-1:0]            w_key;
  logic [VW-1:0]            w_val;
  logic [RW-1:0]            w_rank;
  logic                     w_vld;
  logic [LW-1:0]            eff_limit;
  logic                     evict;
  logic                     have_slot;
  logic [IW-1:0]            slot;
  logic                     pass_end;

  assign w_key  = ram_rdata[KW-1:0];
  assign w_val  = ram_rdata[KW+VW-1:KW];
  assign w_rank = ram_rdata[WW-1:KW+VW];
  assign w_vld  = valid_r[pidx_r];

  assign pass_end = (cnt_r == CW'(ENTRIES)) && pend_r;

  always_comb begin
    if (cap_r == '0) begin
      eff_limit = LW'(1);
    end else if (LW'(cap_r) > LW'(ENTRIES)) begin
      eff_limit = LW'(ENTRIES);
    end else begin
      eff_limit = LW'(cap_r);
    end
  end

  assign evict     = (LW'(count_r) >= eff_limit) && vfound_r;
  assign have_slot = evict || ffound_r;

  always_comb begin
    if (evict) begin
      slot = (ffound_r && (fridx_r < vidx_r)) ? fridx_r : vidx_r;
    end else begin
      slot = fridx_r;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    valid_nxt  = valid_r;
    count_nxt  = count_r;
    cap_nxt    = cap_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    pidx_nxt   = pidx_r;
    found_nxt  = found_r;
    vfound_nxt = vfound_r;
    ffound_nxt = ffound_r;
    ins_nxt    = ins_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    fidx_nxt   = fidx_r;
    frank_nxt  = frank_r;
    fval_nxt   = fval_r;
    vidx_nxt   = vidx_r;
    vrank_nxt  = vrank_r;
    fridx_nxt  = fridx_r;
    tidx_nxt   = tidx_r;
    tval_nxt   = tval_r;
    thr_nxt    = thr_r;
    ram_we     = 1'b0;
    ram_waddr  = pidx_r;
    ram_wdata  = '0;
    ram_raddr  = cnt_r[IW-1:0];
    res        = '0;

    if (cfg_valid) begin
      cap_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          key_nxt    = in_key;
          val_nxt    = in_value;
          found_nxt  = 1'b0;
          vfound_nxt = 1'b0;
          ffound_nxt = 1'b0;
          cnt_nxt    = '0;
          pend_nxt   = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r != CW'(ENTRIES)) begin
          pend_nxt = 1'b1;
          pidx_nxt = cnt_r[IW-1:0];
          cnt_nxt  = cnt_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (w_vld && (w_key == key_r) && !found_r) begin
            found_nxt = 1'b1;
            fidx_nxt  = pidx_r;
            frank_nxt = w_rank;
            fval_nxt  = w_val;
          end
          if (w_vld && (!vfound_r || (w_rank > vrank_r))) begin
            vfound_nxt = 1'b1;
            vidx_nxt   = pidx_r;
            vrank_nxt  = w_rank;
          end
          if (!w_vld && !ffound_r) begin
            ffound_nxt = 1'b1;
            fridx_nxt  = pidx_r;
          end
        end
        if (pass_end) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cnt_nxt  = '0;
        pend_nxt = 1'b0;
        ins_nxt  = 1'b0;
        tidx_nxt = fidx_r;
        thr_nxt  = frank_r;
        if (op_r == lkv_pkg::OP_GET) begin
          tval_nxt  = fval_r;
          state_nxt = S_RESULT;
        end else if (found_r) begin
          tval_nxt  = val_r;
          state_nxt = S_UPDATE;
        end else begin
          ins_nxt  = 1'b1;
          tval_nxt = val_r;
          tidx_nxt = slot;
          if (evict) begin
            valid_nxt[vidx_r] = 1'b0;
          end
          if (have_slot) begin
            valid_nxt[slot] = 1'b1;
            if (!evict) begin
              count_nxt = count_r + CW'(1);
            end
            state_nxt = S_UPDATE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RESULT: begin
        res.valid = 1'b1;
        res.hit   = found_r;
        res.value = found_r ? fval_r : '0;
        if (res_ready) begin
          state_nxt = found_r ? S_UPDATE : S_IDLE;
        end
      end
      S_UPDATE: begin
        if (cnt_r != CW'(ENTRIES)) begin
          pend_nxt = 1'b1;
          pidx_nxt = cnt_r[IW-1:0];
          cnt_nxt  = cnt_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (pidx_r == tidx_r) begin
            ram_we    = 1'b1;
            ram_wdata = {RW'(0), tval_r, key_r};
          end else if (w_vld && (ins_r || (w_rank < thr_r))) begin
            ram_we    = 1'b1;
            ram_wdata = {w_rank + RW'(1), w_val, w_key};
          end
        end
        if (pass_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      count_r  <= '0;
      cap_r    <= lkv_pkg::CAP_W'(lkv_pkg::CAP_RESET);
      cnt_r    <= '0;
      pend_r   <= 1'b0;
      found_r  <= 1'b0;
      vfound_r <= 1'b0;
      ffound_r <= 1'b0;
      ins_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      count_r  <= count_nxt;
      cap_r    <= cap_nxt;
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
      found_r  <= found_nxt;
      vfound_r <= vfound_nxt;
      ffound_r <= ffound_nxt;
      ins_r    <= ins_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r  <= pidx_nxt;
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    val_r   <= val_nxt;
    fidx_r  <= fidx_nxt;
    frank_r <= frank_nxt;
    fval_r  <= fval_nxt;
    vidx_r  <= vidx_nxt;
    vrank_r <= vrank_nxt;
    fridx_r <= fridx_nxt;
    tidx_r  <= tidx_nxt;
    tval_r  <= tval_nxt;
    thr_r   <= thr_nxt;
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("entry count out of step with valid bits");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= ENTRIES)
    else $error("entry count above store depth");

  a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_UPDATE))
    else $error("store written outside the rank pass");

  a_get_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && op_r == lkv_pkg::OP_GET) |=> (state_r == S_RESULT))
    else $error("get finished its search without a result");

endmodule

/* design/lru_key_value_cache.sv */
// Fully associative key-value cache with least-recently-used replacement. Each in_ beat is a
// get (tuser 0) or a put (tuser 1); a get returns one out_ beat with the hit flag in tuser and
// the stored value (0 on a miss) in tdata, a put returns nothing. Entries live in one RAM that
// a single read port visits once per pass. Every item takes one pass to match the key and find
// the oldest and a free entry; a put and a get that hits then take a read-modify-write pass to
// age the ranks, and a get also waits while its result finds the output register full. One item
// is worked on at a time; a finished result waits in an output register so the next item can
// be taken meanwhile. The capacity register written over cfg_ is read as 1 when 0 and as
// ENTRIES when above it, and may only be written while no item is in progress.
module lru_key_value_cache #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [63:0]               in_tdata,   // key[31:0], value[62:32], zero
  input  logic [0:0]                in_tuser,   // op
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [31:0]               out_tdata,  // read_value[30:0], zero
  output logic [0:0]                out_tuser,  // hit
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WW = lkv_pkg::KEY_W + lkv_pkg::VAL_W + IW;

  lkv_pkg::res_t             res;
  logic                      res_ready;
  logic                      ram_we;
  logic [IW-1:0]             ram_waddr;
  logic [WW-1:0]             ram_wdata;
  logic [IW-1:0]             ram_raddr;
  logic [WW-1:0]             ram_rdata;

  logic                      out_valid_r;
  logic                      out_hit_r;
  logic [lkv_pkg::VAL_W-1:0] out_val_r;

  assign cfg_ready = 1'b1;

  lkv_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser[0]),
    .in_key    (in_tdata[lkv_pkg::KEY_W-1:0]),
    .in_value  (in_tdata[lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:lkv_pkg::KEY_W]),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .res       (res),
    .res_ready (res_ready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  lkv_ram #(
    .WIDTH (WW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register, refilled in the cycle the previous beat leaves
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_hit_r <= res.hit;
      out_val_r <= res.value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {1'b0, out_val_r};

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int HOLD_CYCLES    = 400;

  typedef struct packed {
    logic                      hit;
    logic [lkv_pkg::VAL_W-1:0] rd;
  } lookup_t;

  typedef enum bit {ROW_ITEM, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic                      op;
    logic [lkv_pkg::KEY_W-1:0] key;
    logic [lkv_pkg::VAL_W-1:0] val;
    bit                        typed;
    lookup_t                   want;
  } row_t;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [63:0]               in_tdata   = '0;
  logic [0:0]                in_tuser   = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [31:0]               out_tdata;
  logic [0:0]                out_tuser;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [lkv_pkg::CAP_W-1:0] cfg_data   = '0;

  // side data travelling with each input beat
  bit                        beat_typed = 1'b0;
  lookup_t                   beat_want  = '0;

  // cache shadow state
  logic [lkv_pkg::KEY_W-1:0] tag_q  [lkv_pkg::ENTRIES_DEF];
  logic [lkv_pkg::VAL_W-1:0] data_q [lkv_pkg::ENTRIES_DEF];
  bit                        used_q [lkv_pkg::ENTRIES_DEF];
  int unsigned               age_q  [lkv_pkg::ENTRIES_DEF];
  int unsigned               fill_q  = 0;
  logic [lkv_pkg::CAP_W-1:0] limit_q = lkv_pkg::CAP_W'(lkv_pkg::CAP_RESET);

  lookup_t             expected_reads[$];
  row_t                script[$];
  int                  errors   = 0;
  int                  gap_pct  = 25;
  bit                  quiet    = 1'b0;
  bit                  hold_req = 1'b0;
  int                  idle_cnt = 0;

  lru_key_value_cache u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    foreach (used_q[i]) begin
      used_q[i] = 1'b0;
      age_q[i]  = 0;
      tag_q[i]  = '0;
      data_q[i] = '0;
    end
  end

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void promote(input int idx);
    int unsigned r;
    r = age_q[idx];
    for (int i = 0; i < lkv_pkg::ENTRIES_DEF; i++)
      if (used_q[i] && age_q[i] < r) age_q[i]++;
    age_q[idx] = 0;
  endfunction

  function automatic void predict_access(input logic op,
                                         input logic [lkv_pkg::KEY_W-1:0] k,
                                         input logic [lkv_pkg::VAL_W-1:0] v,
                                         output bit has_res, output lookup_t res);
    int          slot;
    int          victim;
    int unsigned lim;
    slot    = -1;
    victim  = -1;
    has_res = (op == lkv_pkg::OP_GET);
    res     = '0;
    for (int i = 0; i < lkv_pkg::ENTRIES_DEF; i++)
      if (slot < 0 && used_q[i] && tag_q[i] == k) slot = i;
    if (op == lkv_pkg::OP_GET) begin
      if (slot >= 0) begin
        res = '{1'b1, data_q[slot]};
        promote(slot);
      end
    end else if (slot >= 0) begin
      data_q[slot] = v;
      promote(slot);
    end else begin
      lim = (limit_q == 0) ? 1 : limit_q;
      if (lim > lkv_pkg::ENTRIES_DEF) lim = lkv_pkg::ENTRIES_DEF;
      if (fill_q >= lim) begin
        for (int i = 0; i < lkv_pkg::ENTRIES_DEF; i++)
          if (used_q[i] && (victim < 0 || age_q[i] > age_q[victim])) victim = i;
        if (victim >= 0) begin
          used_q[victim] = 1'b0;
          fill_q--;
        end
      end
      for (int i = 0; i < lkv_pkg::ENTRIES_DEF; i++)
        if (slot < 0 && !used_q[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < lkv_pkg::ENTRIES_DEF; i++)
          if (used_q[i]) age_q[i]++;
        used_q[slot] = 1'b1;
        tag_q[slot]  = k;
        data_q[slot] = v;
        age_q[slot]  = 0;
        fill_q++;
      end
    end
  endfunction

  // checking and prediction at each accepted beat
  always @(posedge clk) begin : monitor
    lookup_t want;
    lookup_t pred;
    bit      has_res;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) limit_q = cfg_data;
      if (out_tvalid && out_tready) begin
        if (expected_reads.size() == 0) begin
          $error("unexpected result beat: hit %0d read_value %0h", out_tuser[0],
                 out_tdata[lkv_pkg::VAL_W-1:0]);
          errors++;
        end else begin
          want = expected_reads.pop_front();
          if (out_tuser[0] !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, out_tuser[0]);
            errors++;
          end
          if (out_tdata[lkv_pkg::VAL_W-1:0] !== want.rd) begin
            $error("read_value: expected %0h, actual %0h", want.rd,
                   out_tdata[lkv_pkg::VAL_W-1:0]);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_access(in_tuser[0], in_tdata[lkv_pkg::KEY_W-1:0],
                       in_tdata[lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:lkv_pkg::KEY_W],
                       has_res, pred);
        if (has_res) expected_reads.push_back(beat_typed ? beat_want : pred);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("lru_key_value_cache test failed");
      $finish;
    end else
      idle_cnt <= idle_cnt + 1;
  end

  // result side back-pressure
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic op, input logic [lkv_pkg::KEY_W-1:0] k,
                           input logic [lkv_pkg::VAL_W-1:0] v, input bit typed,
                           input lookup_t want);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= {1'b0, v, k};
    in_tuser   <= op;
    beat_typed <= typed;
    beat_want  <= want;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (expected_reads.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [lkv_pkg::CAP_W-1:0] lim);
    in_tvalid <= 1'b0;
    wait_drained();
    // a trailing put gives no result, so let it finish
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int                        limits[10];
    logic [lkv_pkg::KEY_W-1:0] pool[24];
    int                        pool_n;
    logic                      op;
    logic [lkv_pkg::KEY_W-1:0] k;
    logic [lkv_pkg::VAL_W-1:0] v;

    script.push_back('{ROW_ITEM, lkv_pkg::OP_GET, 32'h0000_0000, 31'h0, 1'b1, '{1'b0, 31'h0}});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_GET, 32'h8000_0000, 31'h7FFF_FFFF,
                       1'b1, '{1'b0, 31'h0}});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, '0});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_GET, 32'h7FFF_FFFF, 31'h0,
                       1'b1, '{1'b1, 31'h7FFF_FFFF}});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_PUT, 32'h8000_0000, 31'h0, 1'b0, '0});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_GET, 32'h8000_0000, 31'h0, 1'b1, '{1'b1, 31'h0}});
    // overwrite of a present key
    script.push_back('{ROW_ITEM, lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 31'h2A, 1'b0, '0});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_GET, 32'h7FFF_FFFF, 31'h0,
                       1'b1, '{1'b1, 31'h2A}});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_PUT, 32'hFFFF_FFFF, 31'h5555_5555, 1'b0, '0});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_PUT, 32'h0000_0000, 31'h2AAA_AAAA, 1'b0, '0});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_GET, 32'h0000_0000, 31'h0,
                       1'b1, '{1'b1, 31'h2AAA_AAAA}});
    // limit dropped below the fill level
    script.push_back('{ROW_LIMIT, lkv_pkg::OP_GET, 32'h0, 31'd2, 1'b0, '0});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_PUT, 32'h0000_0011, 31'h1, 1'b0, '0});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_GET, 32'h8000_0000, 31'h0, 1'b1, '{1'b0, 31'h0}});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_GET, 32'h7FFF_FFFF, 31'h0,
                       1'b1, '{1'b1, 31'h2A}});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_PUT, 32'h0000_0022, 31'h2, 1'b0, '0});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_GET, 32'hFFFF_FFFF, 31'h0, 1'b1, '{1'b0, 31'h0}});
    // zero limit behaves as one
    script.push_back('{ROW_LIMIT, lkv_pkg::OP_GET, 32'h0, 31'd0, 1'b0, '0});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_PUT, 32'h0000_0033, 31'h3, 1'b0, '0});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_GET, 32'h0000_0033, 31'h0, 1'b1, '{1'b1, 31'h3}});
    // limit above the entry count is clamped
    script.push_back('{ROW_LIMIT, lkv_pkg::OP_GET, 32'h0, 31'd31, 1'b0, '0});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_PUT, 32'h0000_0044, 31'h4, 1'b0, '0});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_GET, 32'h0000_0044, 31'h0, 1'b1, '{1'b1, 31'h4}});
    script.push_back('{ROW_LIMIT, lkv_pkg::OP_GET, 32'h0, 31'd1, 1'b0, '0});
    script.push_back('{ROW_ITEM, lkv_pkg::OP_GET, 32'h0000_0022, 31'h0, 1'b0, '0});

    limits = '{16, 1, 2, 0, 5, 31, 3, 16, 8, 0};
    limits[9] = $urandom_range(0, 31);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_LIMIT)
        write_limit(script[i].val[lkv_pkg::CAP_W-1:0]);
      else
        send_item(script[i].op, script[i].key, script[i].val, script[i].typed,
                  script[i].want);
    end

    for (int ph = 0; ph < 10; ph++) begin
      write_limit(limits[ph][lkv_pkg::CAP_W-1:0]);
      pool_n = $urandom_range(2, 24);
      foreach (pool[i]) begin
        case ($urandom_range(0, 11))
          0:       pool[i] = 32'h8000_0000;
          1:       pool[i] = 32'h7FFF_FFFF;
          2:       pool[i] = 32'hFFFF_FFFF;
          3:       pool[i] = 32'h0000_0000;
          default: pool[i] = $urandom;
        endcase
      end
      gap_pct = (ph == 6 || ph == 9) ? 0 : $urandom_range(10, 40);
      quiet   = (ph == 9);
      for (int n = 0; n < 100; n++) begin
        if (ph == 2 && n == 30) hold_req = 1'b1;
        if (ph == 4 && n == 50) begin
          in_tvalid <= 1'b0;
          wait_drained();
        end
        op = ($urandom_range(0, 1) == 0) ? lkv_pkg::OP_GET : lkv_pkg::OP_PUT;
        k  = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
        v  = lkv_pkg::VAL_W'($urandom);
        send_item(op, k, v, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_reads.size() == 0)
      $display("lru_key_value_cache test passed");
    else
      $display("lru_key_value_cache test failed");
    $finish;
  end

endmodule
